// File: rtl/core/tpq_pkg.sv
// Shared types and constants for the time-ordered priority queue.
package tpq_pkg;

  localparam int DEPTH     = 16;
  localparam int TIME_BITS = 16;
  localparam int INFO_BITS = 8;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int IN_W      = 24;
  localparam int OUT_W     = 40;

  // Result status codes.
  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  // Item kinds carried on the input tuser bit.
  localparam logic MODE_ENQ = 1'b0;
  localparam logic MODE_DEQ = 1'b1;

  typedef struct packed {
    logic [TIME_BITS-1:0] time_val;
    logic [INFO_BITS-1:0] info;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_WRITE,
    ST_DEQ,
    ST_RESP
  } state_t;

endpackage

// File: rtl/core/time_ordered_priority_queue_unit.sv
// Top level of the time-ordered priority queue with its sequencer and entry memory.
//
// The queue holds up to 16 (time, info) entries in ascending time order in a
// circular single-port-read memory; equal times leave in arrival order. One
// transaction is processed at a time and s_axis_tready is high only while the
// sequencer is idle and reset is released. An enqueue walks back from the tail,
// one memory read and one compare per entry visited, moving each later entry up
// one slot; each step uses the single memory read port and the single time
// comparator. A dequeue reads the head entry, then captures it and advances the
// head; a refused item goes straight to the result state, and the sequencer
// returns to idle once the output register is free. The result sits in an output
// register, so the next transaction may be accepted while an earlier result
// waits on m_axis_tready. Capacity written through cfg_we/cfg_wdata is clamped
// to 1..16.
module time_ordered_priority_queue_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [15:0] item_time, [23:16] item_info
  input  logic [tpq_pkg::IN_W-1:0]  s_axis_tdata,
  // [0] mode
  input  logic                 s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [15:0] out_time, [23:16] out_info, [25:24] status, [30:26] entry_count,
  // [31] is_empty, [32] is_full, [39:33] zero
  output logic [tpq_pkg::OUT_W-1:0] m_axis_tdata,
  input  logic                 cfg_we,
  input  logic [tpq_pkg::CNT_W-1:0] cfg_wdata
);
  import tpq_pkg::*;

  state_t state, state_next;

  entry_t             mem [DEPTH];
  entry_t             rdata;
  entry_t             item;
  logic               mode;
  logic [CNT_W-1:0]   pos;
  logic [ADDR_W-1:0]  head;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   cap;
  entry_t             res;
  logic [1:0]         res_status;

  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  entry_t             mem_wdata;
  logic [ADDR_W-1:0]  mem_raddr;

  logic [ADDR_W-1:0]  slot_cur;
  logic [ADDR_W-1:0]  slot_prev;
  logic               later;
  logic               accept;
  logic               full_now;
  logic               out_free;

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == ST_IDLE) && !rst;
  assign full_now  = (count >= cap);
  assign out_free  = !m_axis_tvalid || m_axis_tready;

  // Physical slots of the current and preceding logical positions.
  assign slot_cur  = head + pos[ADDR_W-1:0];
  assign slot_prev = slot_cur - 1'b1;

  // The shared comparator: does the held entry leave after the new one?
  assign later = (rdata.time_val > item.time_val);

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (s_axis_tuser == MODE_DEQ) begin
            state_next = (count == '0) ? ST_RESP : ST_READ;
          end else if (full_now) begin
            state_next = ST_RESP;
          end else begin
            state_next = (count == '0) ? ST_WRITE : ST_READ;
          end
        end
      end
      ST_READ: begin
        state_next = (mode == MODE_DEQ) ? ST_DEQ : ST_CMP;
      end
      ST_CMP: begin
        if (later && pos != CNT_W'(1)) begin
          state_next = ST_READ;
        end else begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: state_next = ST_RESP;
      ST_DEQ:   state_next = ST_RESP;
      ST_RESP: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  // Memory control outputs.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = slot_cur;
    mem_wdata = item;
    mem_raddr = (mode == MODE_DEQ) ? head : slot_prev;
    case (state)
      ST_CMP: begin
        if (later) begin
          mem_we    = 1'b1;
          mem_wdata = rdata;
        end
      end
      ST_WRITE: mem_we = 1'b1;
      default:  mem_we = 1'b0;
    endcase
  end

  // Entry memory with registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

  // Sequencer state and queue bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      head  <= '0;
      count <= '0;
      cap   <= CNT_W'(DEPTH);
    end else begin
      state <= state_next;
      if (cfg_we) begin
        if (cfg_wdata == '0) begin
          cap <= CNT_W'(1);
        end else if (cfg_wdata > CNT_W'(DEPTH)) begin
          cap <= CNT_W'(DEPTH);
        end else begin
          cap <= cfg_wdata;
        end
      end
      if (state == ST_WRITE) begin
        count <= count + 1'b1;
      end
      if (state == ST_DEQ) begin
        count <= count - 1'b1;
        head  <= (count == CNT_W'(1)) ? '0 : head + 1'b1;
      end
    end
  end

  // Item capture, walk position and result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      mode          <= s_axis_tuser;
      item.time_val <= s_axis_tdata[TIME_BITS-1:0];
      item.info     <= s_axis_tdata[TIME_BITS +: INFO_BITS];
      pos           <= count;
      res           <= '0;
      if (s_axis_tuser == MODE_DEQ) begin
        res_status <= (count == '0) ? STATUS_EMPTY : STATUS_DONE;
      end else begin
        res_status <= full_now ? STATUS_FULL : STATUS_DONE;
      end
    end
    if (state == ST_CMP && later) begin
      pos <= pos - 1'b1;
    end
    if (state == ST_DEQ) begin
      res <= rdata;
    end
  end

  // Output register toward the result stream.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == ST_RESP && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_RESP && out_free) begin
      m_axis_tdata <= {7'b0, full_now, (count == '0), count, res_status,
                       res.info, res.time_val};
    end
  end

endmodule

// File: rtl/core/tpq_checker.sv
// Port-level checker for the time-ordered priority queue, bound to the top level.
module tpq_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [tpq_pkg::OUT_W-1:0]   m_axis_tdata
);
  import tpq_pkg::*;

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // The empty flag agrees with the reported count.
  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[31] == (m_axis_tdata[30:26] == '0)))
    else $error("empty flag disagrees with count");

  // The count never exceeds the memory depth and the status is a known code.
  a_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[30:26] <= CNT_W'(DEPTH))
                      && ((m_axis_tdata[25:24] == STATUS_DONE)
                          || (m_axis_tdata[25:24] == STATUS_FULL)
                          || (m_axis_tdata[25:24] == STATUS_EMPTY)))
    else $error("count or status out of range");

  // A refused dequeue returns no entry and reports an empty queue.
  a_refused: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[25:24] == STATUS_EMPTY)
      |-> (m_axis_tdata[23:0] == '0) && m_axis_tdata[31])
    else $error("refused dequeue returned data");

endmodule

bind time_ordered_priority_queue_unit tpq_checker u_tpq_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// File: sim/tb_top.sv
// Self-checking testbench for the time-ordered priority queue unit.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tpq_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASES      = 10;
  localparam int CHUNK_ITEMS = 25;

  // One predicted result, one field per member.
  typedef struct {
    logic [TIME_BITS-1:0] out_time;
    logic [INFO_BITS-1:0] out_info;
    logic [1:0]           status;
    logic [CNT_W-1:0]     entry_count;
    logic                 is_empty;
    logic                 is_full;
  } outcome_t;

  // Scoreboard: keeps a sorted copy of the queue and the results it implies.
  class tpq_scoreboard;
    entry_t      sorted_q[$];
    outcome_t    outcome_q[$];
    int unsigned capacity;
    int unsigned errors;
    int unsigned checked;
    int unsigned refused_full;
    int unsigned refused_empty;

    function new();
      capacity = DEPTH;
    endfunction

    // Capacity clamps to 1..DEPTH on a write.
    function void set_capacity(logic [CNT_W-1:0] wdata);
      int unsigned v;
      v = wdata;
      if (v == 0) v = 1;
      if (v > DEPTH) v = DEPTH;
      capacity = v;
    endfunction

    function int pending();
      return outcome_q.size();
    endfunction

    // Apply one accepted input transaction and queue the result it causes.
    function void note_item(logic mode, logic [TIME_BITS-1:0] stamp,
                            logic [INFO_BITS-1:0] info);
      outcome_t r;
      entry_t   e;
      int       pos;
      r.out_time = '0;
      r.out_info = '0;
      r.status   = STATUS_DONE;
      if (mode == MODE_ENQ) begin
        if (sorted_q.size() >= capacity) begin
          r.status = STATUS_FULL;
          refused_full++;
        end else begin
          // New entry goes behind every entry with an equal or smaller time.
          pos = sorted_q.size();
          while (pos > 0 && sorted_q[pos-1].time_val > stamp) pos--;
          e.time_val = stamp;
          e.info     = info;
          sorted_q.insert(pos, e);
        end
      end else if (sorted_q.size() == 0) begin
        r.status = STATUS_EMPTY;
        refused_empty++;
      end else begin
        e = sorted_q.pop_front();
        r.out_time = e.time_val;
        r.out_info = e.info;
      end
      r.entry_count = sorted_q.size();
      r.is_empty    = (sorted_q.size() == 0);
      r.is_full     = (sorted_q.size() >= capacity);
      outcome_q.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      end
    endfunction

    // Check one accepted output transaction against the oldest prediction.
    function void check_result(logic [OUT_W-1:0] data);
      outcome_t r;
      if (outcome_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, expected none, actual 0x%0h",
                 $time, data);
        return;
      end
      r = outcome_q.pop_front();
      checked++;
      compare_field("out_time", r.out_time, data[15:0]);
      compare_field("out_info", r.out_info, data[23:16]);
      compare_field("status", r.status, data[25:24]);
      compare_field("entry_count", r.entry_count, data[30:26]);
      compare_field("is_empty", r.is_empty, data[31]);
      compare_field("is_full", r.is_full, data[32]);
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [IN_W-1:0]      s_axis_tdata;
  logic                 s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OUT_W-1:0]     m_axis_tdata;
  logic                 cfg_we;
  logic [CNT_W-1:0]     cfg_wdata;

  logic                 hold_req = 1'b0;
  bit                   hold_done = 1'b0;
  bit                   src_idle_on = 1'b1;
  bit                   sink_idle_on = 1'b1;
  int unsigned          cycle_cnt = 0;
  int unsigned          items_sent = 0;
  int unsigned          cfg_writes = 0;
  int                   hold_cnt;

  tpq_scoreboard sb = new();

  time_ordered_priority_queue_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_cnt);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Input and output monitors; both see pre-edge values.
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready)
      sb.note_item(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[23:16]);
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata);
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        m_axis_tready <= 1'b0;
        for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++) @(posedge clk);
        hold_done = 1'b1;
      end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Offer one transaction and wait until it is taken.
  task automatic send_item(input logic mode, input logic [TIME_BITS-1:0] stamp,
                           input logic [INFO_BITS-1:0] info);
    if (src_idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {info, stamp};
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
  endtask

  // Stop sending and wait until every predicted result has come back.
  // The first edge lets the monitor record the last accepted transaction.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CNT_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    sb.set_capacity(value);
    cfg_we    <= 1'b0;
    cfg_writes++;
  endtask

  // Random transactions; times lean toward ties and the range ends.
  task automatic random_chunk(input int count, input int enq_pct);
    logic                 mode;
    logic [TIME_BITS-1:0] stamp;
    for (int k = 0; k < count; k++) begin
      mode = ($urandom_range(1, 100) <= enq_pct) ? MODE_ENQ : MODE_DEQ;
      case ($urandom_range(0, 5))
        0, 1:    stamp = TIME_BITS'($urandom());
        2, 3:    stamp = TIME_BITS'($urandom_range(0, 7));
        4:       stamp = $urandom_range(0, 1) ? '1 : '0;
        default: stamp = TIME_BITS'($urandom_range(65528, 65535));
      endcase
      send_item(mode, stamp, INFO_BITS'($urandom()));
    end
  endtask

  // Main sequence.
  initial begin
    int caps [PHASES] = '{16, 0, 1, 31, 8, 17, 2, 16, 15, 16};
    int enq_mix [5]   = '{85, 50, 15, 70, 30};
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tuser  <= MODE_ENQ;
    s_axis_tdata  <= '0;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: dequeue while empty, range ends, ties leaving in arrival order.
    send_item(MODE_DEQ, '0, '0);
    send_item(MODE_ENQ, 16'hFFFF, 8'hFF);
    send_item(MODE_ENQ, 16'h0000, 8'h00);
    send_item(MODE_ENQ, 16'd100, 8'h41);
    send_item(MODE_ENQ, 16'd100, 8'h42);
    send_item(MODE_ENQ, 16'd100, 8'h43);
    send_item(MODE_ENQ, 16'd50, 8'h5A);
    repeat (7) send_item(MODE_DEQ, 16'hFFFF, 8'hFF);
    settle();

    // Directed: a written zero acts as one; enqueue while full.
    write_capacity(5'd0);
    send_item(MODE_ENQ, 16'd7, 8'h11);
    send_item(MODE_ENQ, 16'd3, 8'h22);
    send_item(MODE_DEQ, '0, '0);
    settle();

    // Directed: capacity lowered below the held count.
    write_capacity(5'd31);
    send_item(MODE_ENQ, 16'd30, 8'h01);
    send_item(MODE_ENQ, 16'd10, 8'h02);
    send_item(MODE_ENQ, 16'd20, 8'h03);
    settle();
    write_capacity(5'd2);
    send_item(MODE_ENQ, 16'd5, 8'h04);
    send_item(MODE_DEQ, '0, '0);
    send_item(MODE_ENQ, 16'd6, 8'h05);
    send_item(MODE_DEQ, '0, '0);
    send_item(MODE_ENQ, 16'd6, 8'h06);
    settle();

    // Random phases, each under its own capacity.
    for (int p = 0; p < PHASES; p++) begin
      if (p == PHASES - 1) begin
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
      end
      write_capacity(CNT_W'(caps[p]));
      // Receiver holds off while the sender keeps offering, so the unit backs up.
      if (p == 2) hold_req <= 1'b1;
      for (int c = 0; c < 5; c++) begin
        random_chunk(CHUNK_ITEMS, enq_mix[(c + p) % 5]);
        if (p == 5 && c == 2) settle();
      end
      settle();
    end

    repeat (40) @(posedge clk);
    $display("Sent %0d transactions and checked %0d results over %0d capacity writes.",
             items_sent, sb.checked, cfg_writes);
    $display("Refused enqueues: %0d, refused dequeues: %0d, errors: %0d.",
             sb.refused_full, sb.refused_empty, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
